// ===== hdl/ascii_integer_parser_unit_macros.svh =====
`ifndef ASCII_INTEGER_PARSER_UNIT_MACROS_SVH
`define ASCII_INTEGER_PARSER_UNIT_MACROS_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define AIP_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ascii_integer_parser_unit: same-cycle check failed");

// Checks a condition that must hold in the cycle after its trigger.
`define AIP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ascii_integer_parser_unit: next-cycle check failed");

`endif

// ===== hdl/aip_pkg.sv =====
package aip_pkg;

  // Field widths of the channels.
  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int STOP_W      = 16;
  localparam int RADIX_W     = 6;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // Default saturation point of the position counter.
  localparam int unsigned POSITION_MAX_DEFAULT = 32'd65535;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX       = 4'd1;

  // Fixed bases used by prefix detection.
  localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;

  // Clamp limits of the two parse modes.
  localparam logic [VALUE_W-1:0] LIM_UMAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_SMIN = 64'h8000_0000_0000_0000;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classification of one character, as the front hands it to the back.
  typedef struct packed {
    logic               is_nul;
    logic               is_space;
    logic               is_sign;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               digit_ok;
    logic [RADIX_W-1:0] digit;
  } char_class_t;

  // Fill status of the queue.
  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

// ===== hdl/aip_channels.sv =====
// Input channel: one character per beat.
interface aip_in_if;
  logic                         valid;
  logic                         ready;
  logic [aip_pkg::CHAR_W-1:0]   character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// Result channel: one parsed integer per beat.
interface aip_out_if;
  logic                         valid;
  logic                         ready;
  logic [aip_pkg::VALUE_W-1:0]  value;
  logic [aip_pkg::STOP_W-1:0]   stop_position;
  logic                         saturated;

  modport source (output valid, output value, output stop_position, output saturated,
                  input ready);
  modport sink   (input valid, input value, input stop_position, input saturated,
                  output ready);
endinterface

// Configuration write channel.
interface aip_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aip_pkg::CFG_INDEX_W-1:0]  index;
  logic [aip_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ascii_integer_parser_unit.sv =====
// Streaming ASCII-to-integer parser. Each input beat carries one byte of a string; a NUL byte
// ends the string. One result beat comes out per string, when parsing stops at the NUL, at a
// byte that is not a valid digit for the base, or on overflow, which clamps the value and sets
// saturated. Bytes after a stop are dropped through the NUL. The unit sustains one character
// per clock while no result waits: the front classifies a byte in the cycle it is taken and
// writes it into a two-entry queue, and the back consumes one queued byte per cycle, doing the
// 64-by-6-bit multiply-accumulate and overflow compare in that cycle. A result becomes valid
// at the edge at which its stopping byte leaves the queue and loads the output register. The
// back holds only while an earlier result waits in the output register; the input stalls once
// both queue entries are occupied. Write signed_mode and radix between beats only while no
// byte or result is in flight; radix is sampled at the start of each string's base detection.
`include "ascii_integer_parser_unit_macros.svh"

module ascii_integer_parser_unit #(
  parameter int unsigned POSITION_MAX = aip_pkg::POSITION_MAX_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  aip_in_if.sink    in_ch,
  aip_out_if.source out_ch,
  aip_cfg_if.sink   cfg_ch
);

  logic                          signed_mode_r;
  logic [aip_pkg::RADIX_W-1:0]   radix_r;
  logic                          push;
  logic                          pop;
  aip_pkg::char_class_t          cls_in;
  aip_pkg::char_class_t          cls_out;
  aip_pkg::queue_status_t        q_stat;
  logic                          sat_result_ok;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
      radix_r       <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        aip_pkg::CFG_SIGNED_MODE: signed_mode_r <= cfg_ch.data[0];
        aip_pkg::CFG_RADIX:       radix_r <= cfg_ch.data[aip_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: take and classify characters.
  aip_front u_front (
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .push   (push),
    .cls    (cls_in)
  );

  // Queue between front and back.
  aip_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cls_in),
    .pop   (pop),
    .dout  (cls_out),
    .stat  (q_stat)
  );

  // Back: phase machine, accumulator and result register.
  aip_back #(
    .POSITION_MAX (POSITION_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .signed_mode (signed_mode_r),
    .radix       (radix_r),
    .item        (cls_out),
    .q_empty     (q_stat.empty),
    .pop         (pop),
    .out_ch      (out_ch)
  );

  // A clamped result carries one of the mode limits and a zero stop position.
  assign sat_result_ok = (out_ch.stop_position == '0) &&
                         ((out_ch.value == aip_pkg::LIM_UMAX) ||
                          (out_ch.value == aip_pkg::LIM_SMAX) ||
                          (out_ch.value == aip_pkg::LIM_SMIN));

  // A full queue must stall the input side.
  `AIP_ASSERT_SAME(a_full_stalls_input, q_stat.full, !in_ch.ready)

  // A beat written without a read grows the queue by exactly one entry.
  `AIP_ASSERT_NEXT(a_queue_grows, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1)

  // Saturated results are well formed.
  `AIP_ASSERT_SAME(a_sat_is_limit, out_ch.valid && out_ch.saturated, sat_result_ok)

endmodule

// ===== hdl/aip_front.sv =====
module aip_front (
  aip_in_if.sink               in_ch,
  input  logic                 q_full,
  output logic                 push,
  output aip_pkg::char_class_t cls
);

  localparam int CHAR_W = aip_pkg::CHAR_W;
  localparam int RADIX_W = aip_pkg::RADIX_W;

  // Character codes recognized by the classifier.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  logic [CHAR_W-1:0] c;

  // A beat is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign c           = in_ch.character;

  // Classify the character and work out its digit value.
  always_comb begin
    cls          = '0;
    cls.is_nul   = (c == CH_NUL);
    cls.is_space = (c inside {[CH_TAB:CH_CR]}) || (c == CH_SPACE);
    cls.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    cls.is_minus = (c == CH_MINUS);
    cls.is_zero  = (c == CH_0);
    cls.is_x     = (c == CH_LX) || (c == CH_UX);
    if (c inside {[CH_0:CH_9]}) begin
      cls.digit_ok = 1'b1;
      cls.digit    = RADIX_W'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      cls.digit_ok = 1'b1;
      cls.digit    = RADIX_W'(c - CH_LA + 8'd10);
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      cls.digit_ok = 1'b1;
      cls.digit    = RADIX_W'(c - CH_UA + 8'd10);
    end
  end

endmodule

// ===== hdl/aip_queue.sv =====
module aip_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  aip_pkg::char_class_t   din,
  input  logic                   pop,
  output aip_pkg::char_class_t   dout,
  output aip_pkg::queue_status_t stat
);

  localparam int DEPTH = aip_pkg::QUEUE_DEPTH;
  localparam int PTR_W = aip_pkg::QUEUE_PTR_W;
  localparam int CNT_W = aip_pkg::QUEUE_CNT_W;

  aip_pkg::char_class_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;

  // Pointers wrap at the last entry.
  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  // Entry storage; writes only land while there is room.
  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !stat.full) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop && !stat.empty) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if ((push && !stat.full) && !(pop && !stat.empty)) begin
        count_r <= count_r + 1'b1;
      end else if (!(push && !stat.full) && (pop && !stat.empty)) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/aip_back.sv =====
module aip_back #(
  parameter int unsigned POSITION_MAX = aip_pkg::POSITION_MAX_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        signed_mode,
  input  logic [aip_pkg::RADIX_W-1:0] radix,
  input  aip_pkg::char_class_t        item,
  input  logic                        q_empty,
  output logic                        pop,
  aip_out_if.source                   out_ch
);

  localparam int VALUE_W = aip_pkg::VALUE_W;
  localparam int STOP_W  = aip_pkg::STOP_W;
  localparam int RADIX_W = aip_pkg::RADIX_W;
  localparam int PROD_W  = VALUE_W + RADIX_W;
  localparam int POS_W   = $clog2(64'(POSITION_MAX) + 64'd1);

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_SIGN    = 3'd1,
    PH_BASE    = 3'd2,
    PH_AFTER0  = 3'd3,
    PH_WS      = 3'd4,
    PH_DIGIT   = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  phase_t             phase_r;
  logic [VALUE_W-1:0] acc_r;
  logic               neg_r;
  logic [RADIX_W-1:0] base_r;
  logic [POS_W-1:0]   pos_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [STOP_W-1:0]  out_stop_r;
  logic               out_sat_r;

  phase_t             phase_nxt;
  logic [VALUE_W-1:0] acc_nxt;
  logic               neg_nxt;
  logic [RADIX_W-1:0] base_nxt;
  logic               step;
  logic               done;
  logic               restart;
  logic               emit;
  logic [VALUE_W-1:0] emit_value;
  logic [STOP_W-1:0]  emit_stop;
  logic               emit_sat;
  phase_t             after_base;
  logic [VALUE_W-1:0] lim;
  logic [PROD_W-1:0]  mac;

  // The back takes one beat from the queue whenever the output register is free.
  assign step = !q_empty && (!out_valid_r || out_ch.ready);
  assign pop  = step;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value         = out_value_r;
  assign out_ch.stop_position = out_stop_r;
  assign out_ch.saturated     = out_sat_r;

  // Walk the phases that one character passes through, then run the digit step.
  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    base_nxt   = base_r;
    done       = 1'b0;
    restart    = 1'b0;
    emit       = 1'b0;
    emit_value = '0;
    emit_stop  = '0;
    emit_sat   = 1'b0;
    mac        = '0;
    after_base = signed_mode ? PH_DIGIT : PH_WS;
    if (!signed_mode) begin
      lim = aip_pkg::LIM_UMAX;
    end else if (neg_r) begin
      lim = aip_pkg::LIM_SMIN;
    end else begin
      lim = aip_pkg::LIM_SMAX;
    end

    // Leading whitespace is skipped in signed mode only.
    if (phase_nxt == PH_LEAD) begin
      if (signed_mode && item.is_space) begin
        done = 1'b1;
      end else begin
        phase_nxt = PH_SIGN;
      end
    end

    // A sign is consumed; only signed mode honors the minus.
    if (!done && phase_nxt == PH_SIGN) begin
      phase_nxt = PH_BASE;
      if (item.is_sign) begin
        if (signed_mode && item.is_minus) begin
          neg_nxt = 1'b1;
        end
        done = 1'b1;
      end
    end

    // Base selection: explicit radix, or a leading zero starts prefix detection.
    if (!done && phase_nxt == PH_BASE) begin
      if (radix != '0) begin
        base_nxt  = radix;
        phase_nxt = after_base;
      end else if (item.is_zero) begin
        phase_nxt = PH_AFTER0;
        done      = 1'b1;
      end else begin
        base_nxt  = aip_pkg::BASE_DEC;
        phase_nxt = after_base;
      end
    end

    // After a leading zero, an x selects hex and anything else octal.
    if (!done && phase_nxt == PH_AFTER0) begin
      phase_nxt = after_base;
      if (item.is_x) begin
        base_nxt = aip_pkg::BASE_HEX;
        done     = 1'b1;
      end else begin
        base_nxt = aip_pkg::BASE_OCT;
      end
    end

    // Whitespace between prefix and digits, unsigned mode only.
    if (!done && phase_nxt == PH_WS) begin
      if (item.is_space) begin
        done = 1'b1;
      end else begin
        phase_nxt = PH_DIGIT;
      end
    end

    // Digit step: stop on end of string, a bad digit or overflow, else multiply-accumulate.
    if (!done && phase_nxt == PH_DIGIT) begin
      done = 1'b1;
      if (item.is_nul) begin
        emit       = 1'b1;
        emit_value = neg_r ? (VALUE_W'(0) - acc_r) : acc_r;
        emit_stop  = STOP_W'(pos_r);
        restart    = 1'b1;
      end else if (!item.digit_ok || (item.digit >= base_nxt)) begin
        emit       = 1'b1;
        emit_value = neg_r ? (VALUE_W'(0) - acc_r) : acc_r;
        emit_stop  = STOP_W'(pos_r);
        phase_nxt  = PH_DISCARD;
      end else begin
        mac = PROD_W'(acc_r) * PROD_W'(base_nxt) + PROD_W'(item.digit);
        if (mac > PROD_W'(lim)) begin
          emit       = 1'b1;
          emit_value = (signed_mode && neg_r) ? (VALUE_W'(0) - lim) : lim;
          emit_stop  = '0;
          emit_sat   = 1'b1;
          phase_nxt  = PH_DISCARD;
        end else begin
          acc_nxt = mac[VALUE_W-1:0];
        end
      end
    end

    // Discard up to and including the end of string.
    if (!done) begin
      if (item.is_nul) begin
        restart = 1'b1;
      end else begin
        phase_nxt = PH_DISCARD;
      end
    end
  end

  // Parser state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      base_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loads the register; otherwise a taken result empties it.
      if (step && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        if (restart) begin
          phase_r <= PH_LEAD;
          acc_r   <= '0;
          neg_r   <= 1'b0;
          base_r  <= '0;
          pos_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          acc_r   <= acc_nxt;
          neg_r   <= neg_nxt;
          base_r  <= base_nxt;
          if (pos_r < POS_W'(POSITION_MAX)) begin
            pos_r <= pos_r + 1'b1;
          end
        end
        if (emit) begin
          out_value_r <= emit_value;
          out_stop_r  <= emit_stop;
          out_sat_r   <= emit_sat;
        end
      end
    end
  end

endmodule
